### rtl/core/kefq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kefq_pkg
// Shared types and codes for the keypad event qualifier with key FIFO.
// ----------------------------------------------------------------------------
package kefq_pkg;

	localparam logic [1:0] OP_POLL     = 2'd0;
	localparam logic [1:0] OP_POLL_IRQ = 2'd1;
	localparam logic [1:0] OP_POP      = 2'd2;
	localparam logic [1:0] OP_CLEAR    = 2'd3;

	localparam logic CFG_DEBOUNCE = 1'b0;
	localparam logic CFG_RELEASE  = 1'b1;

	localparam logic [15:0] DEBOUNCE_RESET = 16'd50;
	localparam logic [15:0] RELEASE_RESET  = 16'd200;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [31:0] now_ms;
		logic [2:0]  scanned_key;
	} in_item_t;

	typedef struct packed {
		logic        key_accepted;
		logic        overflow_cleared;
		logic        pop_valid;
		logic [2:0]  popped_key;
		logic [4:0]  queued_count;
		logic [2:0]  held_key;
		logic [31:0] press_total;
	} out_item_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_WB
	} ctl_state_t;

	typedef struct packed {
		logic load_in;
		logic exec;
		logic load_out;
	} dp_cmd_t;

endpackage

### rtl/core/kefq_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kefq_ctrl
// Sequencer: takes a transaction, runs the execute step, then hands the
// result to the output register when that register is free.
// ----------------------------------------------------------------------------
module kefq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  logic               out_ready,
	output kefq_pkg::dp_cmd_t  cmd
);

	kefq_pkg::ctl_state_t state_q, state_d;
	logic                 out_valid_q;
	logic                 out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			kefq_pkg::ST_IDLE: begin
				if (in_valid) state_d = kefq_pkg::ST_EXEC;
			end
			kefq_pkg::ST_EXEC: begin
				state_d = kefq_pkg::ST_WB;
			end
			kefq_pkg::ST_WB: begin
				if (out_free) state_d = kefq_pkg::ST_IDLE;
			end
			default: begin
				state_d = kefq_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready     = (state_q == kefq_pkg::ST_IDLE);
		cmd.load_in  = (state_q == kefq_pkg::ST_IDLE) && in_valid;
		cmd.exec     = (state_q == kefq_pkg::ST_EXEC);
		cmd.load_out = (state_q == kefq_pkg::ST_WB) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= kefq_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

### rtl/core/kefq_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kefq_datapath
// Debounce and release timers, press counter, key FIFO memory and the
// result registers.
// ----------------------------------------------------------------------------
module kefq_datapath #(
	parameter int FIFO_DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  kefq_pkg::dp_cmd_t   cmd,
	input  kefq_pkg::in_item_t  in_data,
	output kefq_pkg::out_item_t out_data,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [15:0]         cfg_wdata
);

	localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(FIFO_DEPTH);

	kefq_pkg::in_item_t  item_q;
	kefq_pkg::out_item_t out_q;

	logic [15:0] debounce_q, release_q;
	logic [31:0] last_scan_q, press_q, total_q;
	logic [2:0]  held_q;
	logic [PTR_W-1:0] rptr_q, wptr_q;
	logic [CNT_W-1:0] fill_q;

	logic [2:0] mem [FIFO_DEPTH];
	logic [2:0] rdata_q;

	// results captured at execute, popped key joins from the memory read
	logic        acc_s1, empt_s1, pval_s1;
	logic [4:0]  cnt_s1;
	logic [2:0]  held_s1;
	logic [31:0] total_s1;

	logic [31:0] scan_diff, press_diff;
	logic        scan_ok, rel_exp, accept, full, pop_ok;
	logic [PTR_W-1:0] waddr, rptr_d, wptr_d;
	logic [CNT_W-1:0] fill_d;
	logic [2:0]  held_d;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		ptr_inc = (p == PTR_LAST) ? '0 : p + 1'b1;
	endfunction

	always_comb begin
		scan_diff  = item_q.now_ms - last_scan_q;
		press_diff = item_q.now_ms - press_q;
		scan_ok    = (item_q.opcode == kefq_pkg::OP_POLL_IRQ) &&
			(scan_diff >= {16'd0, debounce_q});
		rel_exp    = press_diff > {16'd0, release_q};
		accept     = scan_ok && (item_q.scanned_key != 3'd0) &&
			((item_q.scanned_key != held_q) || rel_exp);
		full       = (fill_q == CNT_FULL);
		pop_ok     = (item_q.opcode == kefq_pkg::OP_POP) && (fill_q != '0);
		waddr      = full ? '0 : wptr_q;

		rptr_d = rptr_q;
		wptr_d = wptr_q;
		fill_d = fill_q;
		held_d = held_q;
		unique case (item_q.opcode)
			kefq_pkg::OP_POLL, kefq_pkg::OP_POLL_IRQ: begin
				if (accept) begin
					held_d = item_q.scanned_key;
					wptr_d = ptr_inc(waddr);
					if (full) begin
						rptr_d = '0;
						fill_d = CNT_W'(1);
					end else begin
						fill_d = fill_q + 1'b1;
					end
				end else if (held_q != 3'd0 && rel_exp) begin
					held_d = 3'd0;
				end
			end
			kefq_pkg::OP_POP: begin
				if (pop_ok) begin
					rptr_d = ptr_inc(rptr_q);
					fill_d = fill_q - 1'b1;
				end
			end
			kefq_pkg::OP_CLEAR: begin
				rptr_d = '0;
				wptr_d = '0;
				fill_d = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q  <= kefq_pkg::DEBOUNCE_RESET;
			release_q   <= kefq_pkg::RELEASE_RESET;
			last_scan_q <= '0;
			press_q     <= '0;
			total_q     <= '0;
			held_q      <= '0;
			rptr_q      <= '0;
			wptr_q      <= '0;
			fill_q      <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == kefq_pkg::CFG_DEBOUNCE) debounce_q <= cfg_wdata;
				else release_q <= cfg_wdata;
			end
			if (cmd.exec) begin
				if (scan_ok) last_scan_q <= item_q.now_ms;
				if (accept) begin
					press_q <= item_q.now_ms;
					total_q <= total_q + 32'd1;
				end
				held_q <= held_d;
				rptr_q <= rptr_d;
				wptr_q <= wptr_d;
				fill_q <= fill_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) item_q <= in_data;
		if (cmd.exec) begin
			if (accept) mem[waddr] <= item_q.scanned_key;
			rdata_q  <= mem[rptr_q];
			acc_s1   <= accept;
			empt_s1  <= accept && full;
			pval_s1  <= pop_ok;
			cnt_s1   <= 5'(fill_d);
			held_s1  <= held_d;
			total_s1 <= accept ? total_q + 32'd1 : total_q;
		end
		if (cmd.load_out) begin
			out_q.key_accepted     <= acc_s1;
			out_q.overflow_cleared <= empt_s1;
			out_q.pop_valid        <= pval_s1;
			out_q.popped_key       <= pval_s1 ? rdata_q : 3'd0;
			out_q.queued_count     <= cnt_s1;
			out_q.held_key         <= held_s1;
			out_q.press_total      <= total_s1;
		end
	end

	assign out_data = out_q;

endmodule

### rtl/core/keypad_event_qualifier_fifo_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keypad_event_qualifier_fifo_top
// Qualifies keypad polls against debounce and release timers and queues
// accepted keys in a ring FIFO with pop and clear commands.
// ----------------------------------------------------------------------------
// Flow: an input transaction is captured, then executed with FIFO memory
//   access, then handed off to the output register.
// Sequencing: a new transaction is taken only once the sequencer has stepped
//   capture -> execute -> result hand-off; a pending result waits in the
//   output register while the next transaction is taken.
// Reset: asynchronous, active low; timers, counter, FIFO pointers and count
//   clear, registers load debounce 50 and release 200. FIFO memory is not
//   cleared.
module keypad_event_qualifier_fifo_top #(
	parameter int FIFO_DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  kefq_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output kefq_pkg::out_item_t out_data,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [15:0]         cfg_wdata
);

	kefq_pkg::dp_cmd_t cmd;

	kefq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	kefq_datapath #(
		.FIFO_DEPTH (FIFO_DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_data   (in_data),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	a_accept_exec : assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> cmd.exec)
		else $error("execute did not follow an accepted transaction");

	a_exec_busy : assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |=> !in_ready)
		else $error("input ready during result hand-off");

	a_accept_pop_excl : assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.key_accepted && out_data.pop_valid))
		else $error("result flags both a push and a pop");

	a_overflow_push : assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.overflow_cleared) |-> out_data.key_accepted)
		else $error("overflow clear without an accepted key");

endmodule
